/* rtl/rrsd_pkg.sv */
// Types and constants shared by the range reply stream decoder modules.
`timescale 1ns / 1ps
`default_nettype none

package rrsd_pkg;

  localparam logic [7:0] LineFeed = 8'h0A;
  localparam logic [7:0] CharBias = 8'h30;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [1:0] ModeSingle   = 2'd1;
  localparam logic [1:0] ModeStrength = 2'd2;

  localparam logic [1:0] LineStatus    = 2'd1;
  localparam logic [1:0] LineTimestamp = 2'd2;
  localparam logic [1:0] LineData      = 2'd3;

  localparam logic [2:0] TimestampChars = 3'd4;
  localparam logic [2:0] GroupShort     = 3'd3;
  localparam logic [2:0] GroupLong      = 3'd6;
  localparam logic [2:0] CharsMax       = 3'd7;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_DATA    = 2'd1,
    VERDICT_NO_DATA = 2'd2,
    VERDICT_ERROR   = 2'd3
  } rrsd_verdict_e;

  typedef enum logic [1:0] {
    KIND_TIMESTAMP = 2'd0,
    KIND_MEASURE   = 2'd1,
    KIND_END_OK    = 2'd2,
    KIND_END_ERROR = 2'd3
  } rrsd_kind_e;

  typedef struct packed {
    logic [1:0]    line_index;
    logic [2:0]    chars_in_line;
    logic [7:0]    status_first_char;
    rrsd_verdict_e reply_verdict;
    logic [5:0]    held_char;
    logic          held_valid;
    logic [35:0]   group_acc;
    logic [2:0]    group_count;
    logic          last_lf;
  } rrsd_state_t;

  typedef struct packed {
    rrsd_kind_e  kind;
    logic [23:0] main_value;
    logic [17:0] strength_value;
  } rrsd_result_t;

endpackage

`default_nettype wire

/* rtl/rrsd_decode.sv */
// Next-state and result logic for one reply byte of the range reply decoder.
`timescale 1ns / 1ps
`default_nettype none

module rrsd_decode
  import rrsd_pkg::*;
(
  input  wire rrsd_state_t  state_i,
  input  wire logic [7:0]   reply_byte_i,
  input  wire logic [1:0]   reply_mode_i,
  output rrsd_state_t  state_o,
  output logic         res_valid_o,
  output rrsd_result_t res_o
);

  logic [7:0]  biased;
  logic [5:0]  six;
  logic [35:0] acc_push;
  logic [2:0]  count_push;
  logic [2:0]  group_size;
  logic        zero_code;
  logic        nine_code;

  assign biased     = reply_byte_i - CharBias;
  assign six        = biased[5:0];
  assign group_size = (reply_mode_i == ModeStrength) ? GroupLong : GroupShort;
  assign zero_code  = (state_i.status_first_char == CharZero) && (reply_byte_i == CharZero);
  assign nine_code  = (state_i.status_first_char == CharNine) && (reply_byte_i == CharNine);
  assign acc_push   = {state_i.group_acc[29:0], state_i.held_char};
  assign count_push = state_i.group_count + 3'd1;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_TIMESTAMP, main_value: '0, strength_value: '0};
    if (reply_byte_i == LineFeed) begin
      if (state_i.last_lf) begin
        res_valid_o = 1'b1;
        res_o.kind  = ((state_i.reply_verdict == VERDICT_DATA) ||
                       (state_i.reply_verdict == VERDICT_NO_DATA)) ?
                      KIND_END_OK : KIND_END_ERROR;
        state_o     = '0;
      end else begin
        if ((state_i.line_index == LineStatus) &&
            (state_i.reply_verdict == VERDICT_PENDING)) begin
          state_o.reply_verdict = VERDICT_ERROR;
        end
        if (state_i.line_index == LineTimestamp) begin
          state_o.group_acc = '0;
        end
        if (state_i.line_index != LineData) begin
          state_o.line_index = state_i.line_index + 2'd1;
        end
        state_o.chars_in_line = '0;
        state_o.held_valid    = 1'b0;
        state_o.held_char     = '0;
        state_o.last_lf       = 1'b1;
      end
    end else begin
      state_o.last_lf = 1'b0;
      case (state_i.line_index)
        LineStatus: begin
          if (state_i.chars_in_line == 3'd0) begin
            state_o.status_first_char = reply_byte_i;
          end else if (state_i.chars_in_line == 3'd1) begin
            if (reply_mode_i == ModeSingle) begin
              state_o.reply_verdict = zero_code ? VERDICT_DATA : VERDICT_ERROR;
            end else begin
              state_o.reply_verdict = nine_code ? VERDICT_DATA :
                                      (zero_code ? VERDICT_NO_DATA : VERDICT_ERROR);
            end
          end
        end
        LineTimestamp: begin
          if ((state_i.reply_verdict == VERDICT_DATA) &&
              (state_i.chars_in_line < TimestampChars)) begin
            state_o.group_acc = {state_i.group_acc[29:0], six};
            if (state_i.chars_in_line == TimestampChars - 3'd1) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_TIMESTAMP;
              res_o.main_value  = state_o.group_acc[23:0];
              state_o.group_acc = '0;
            end
          end
        end
        LineData: begin
          if (state_i.reply_verdict == VERDICT_DATA) begin
            if (state_i.held_valid) begin
              state_o.group_acc   = acc_push;
              state_o.group_count = count_push;
              if (count_push >= group_size) begin
                res_valid_o = 1'b1;
                res_o.kind  = KIND_MEASURE;
                if (group_size == GroupLong) begin
                  res_o.main_value     = {6'd0, acc_push[35:18]};
                  res_o.strength_value = acc_push[17:0];
                end else begin
                  res_o.main_value = {6'd0, acc_push[17:0]};
                end
                state_o.group_acc   = '0;
                state_o.group_count = '0;
              end
            end
            state_o.held_char  = six;
            state_o.held_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (state_i.chars_in_line != CharsMax) begin
        state_o.chars_in_line = state_i.chars_in_line + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/range_reply_stream_decoder_core.sv */
// Top level of the range reply stream decoder: input stage, decode state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a range finder text reply, one byte per beat, into timestamp, measurement
// and end-of-reply beats. A new byte is taken in every cycle as long as the output
// side keeps up; each byte passes an input register and then one decode step into the
// result register, which drives the output. The user must write the reply mode
// register through cfg_we_i only while no byte is in flight; the block does not
// enforce this. A write applies from the next byte on, also mid-reply. A line feed
// right after another line feed ends the reply and clears the decoder state.
module range_reply_stream_decoder_core
  import rrsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  reply_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       item_kind_o,
  output logic [23:0]      main_value_o,
  output logic [17:0]      strength_value_o
);

  logic [1:0]   mode_q;
  logic         in_valid_q;
  logic [7:0]   byte_q;
  rrsd_state_t  st_q;
  rrsd_state_t  st_d;
  logic         res_valid;
  rrsd_result_t res;
  logic         out_valid_q;
  rrsd_result_t out_q;
  logic         out_free;
  logic         proc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  rrsd_decode u_decode (
    .state_i      (st_q),
    .reply_byte_i (byte_q),
    .reply_mode_i (mode_q),
    .state_o      (st_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      in_valid_q  <= 1'b0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc) begin
        st_q <= st_d;
      end
      if (out_free) begin
        out_valid_q <= proc && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= reply_byte_i;
    end
    if (proc && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = out_q.kind;
  assign main_value_o     = out_q.main_value;
  assign strength_value_o = out_q.strength_value;

  a_end_clears_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res_valid && (res.kind == KIND_END_OK || res.kind == KIND_END_ERROR)
    |=> st_q == '0)
    else $error("decoder state not cleared after end of reply");

  a_end_beat_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == KIND_END_OK || out_q.kind == KIND_END_ERROR)
    |-> out_q.main_value == '0 && out_q.strength_value == '0)
    else $error("end of reply beat carries a value");

  a_state_holds_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(st_q))
    else $error("decoder state changed without a byte");

  a_timestamp_no_strength : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_TIMESTAMP |-> out_q.strength_value == '0)
    else $error("timestamp beat carries a strength");

endmodule

`default_nettype wire

/* bench/range_reply_stream_decoder_core_test.sv */
// Self-checking bench for the range reply stream decoder core with directed and random replies.
`timescale 1ns / 1ps

module range_reply_stream_decoder_core_test;
  import rrsd_pkg::*;

  localparam int RandomBytes  = 1450;
  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  reply_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  item_kind_o;
  logic [23:0] main_value_o;
  logic [17:0] strength_value_o;

  range_reply_stream_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .reply_byte_i    (reply_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .main_value_o    (main_value_o),
    .strength_value_o(strength_value_o)
  );

  logic [1:0]    cur_mode;
  logic [1:0]    line_no;
  logic [2:0]    line_chars;
  logic [7:0]    status_lead;
  rrsd_verdict_e verdict;
  logic [5:0]    pend_char;
  logic          pend_ok;
  logic [35:0]   acc;
  logic [2:0]    acc_count;
  logic          prev_lf;

  rrsd_result_t predicted_beats[$];
  rrsd_result_t want;
  int           errors;
  int           bytes_sent;
  int           idle_cycles;
  int           kind_seen[4];
  bit           quiet;

  function automatic void clear_decoder();
    line_no     = '0;
    line_chars  = '0;
    status_lead = '0;
    verdict     = VERDICT_PENDING;
    pend_char   = '0;
    pend_ok     = 1'b0;
    acc         = '0;
    acc_count   = '0;
    prev_lf     = 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output rrsd_result_t r);
    logic [7:0] diff;
    logic [5:0] sixb;
    logic [2:0] size;
    bit         zero;
    bit         nine;
    bit         hit;
    r    = '0;
    hit  = 1'b0;
    diff = b - CharBias;
    sixb = diff[5:0];
    if (b == LineFeed) begin
      if (prev_lf) begin
        r.kind = (verdict == VERDICT_DATA || verdict == VERDICT_NO_DATA) ?
                 KIND_END_OK : KIND_END_ERROR;
        clear_decoder();
        return 1'b1;
      end
      if (line_no == LineStatus && verdict == VERDICT_PENDING) verdict = VERDICT_ERROR;
      if (line_no == LineTimestamp) acc = '0;
      if (line_no != LineData) line_no = line_no + 2'd1;
      line_chars = '0;
      pend_ok    = 1'b0;
      pend_char  = '0;
      prev_lf    = 1'b1;
      return 1'b0;
    end
    prev_lf = 1'b0;
    case (line_no)
      LineStatus: begin
        if (line_chars == 3'd0) begin
          status_lead = b;
        end else if (line_chars == 3'd1) begin
          zero = (status_lead == CharZero) && (b == CharZero);
          nine = (status_lead == CharNine) && (b == CharNine);
          if (cur_mode == ModeSingle) begin
            verdict = zero ? VERDICT_DATA : VERDICT_ERROR;
          end else begin
            verdict = nine ? VERDICT_DATA : (zero ? VERDICT_NO_DATA : VERDICT_ERROR);
          end
        end
      end
      LineTimestamp: begin
        if (verdict == VERDICT_DATA && line_chars < TimestampChars) begin
          acc = {acc[29:0], sixb};
          if (line_chars == TimestampChars - 3'd1) begin
            r.kind       = KIND_TIMESTAMP;
            r.main_value = acc[23:0];
            acc          = '0;
            hit          = 1'b1;
          end
        end
      end
      LineData: begin
        if (verdict == VERDICT_DATA) begin
          if (pend_ok) begin
            size      = (cur_mode == ModeStrength) ? GroupLong : GroupShort;
            acc       = {acc[29:0], pend_char};
            acc_count = acc_count + 3'd1;
            if (acc_count >= size) begin
              r.kind = KIND_MEASURE;
              if (size == GroupLong) begin
                r.main_value     = {6'd0, acc[35:18]};
                r.strength_value = acc[17:0];
              end else begin
                r.main_value = {6'd0, acc[17:0]};
              end
              acc       = '0;
              acc_count = '0;
              hit       = 1'b1;
            end
          end
          pend_char = sixb;
          pend_ok   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (line_chars < CharsMax) line_chars = line_chars + 3'd1;
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == LineFeed);
    return c;
  endfunction

  function automatic logic [7:0] data_char();
    if ($urandom_range(0, 7) == 0) return any_char();
    return 8'($urandom_range(8'h30, 8'h6F));
  endfunction

  function automatic logic [7:0] status_char();
    case ($urandom_range(0, 2))
      0: return CharZero;
      1: return CharNine;
      default: return any_char();
    endcase
  endfunction

  // Called at a falling edge; leaves valid high so back-to-back beats need no gap.
  task automatic send_byte(input logic [7:0] b);
    int           gap;
    rrsd_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    reply_byte_i <= b;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_byte(b, r)) predicted_beats.push_back(r);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (predicted_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_idle();
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  task automatic test_short_status();
    write_mode(2'd0);
    send_text("\n0\n\n");
  endtask

  task automatic test_distance_reply();
    write_mode(2'd3);
    send_byte(8'h00);
    send_text("\n99\noooo\n000");
    send_byte(8'hFF);
    send_text("\n\n");
  endtask

  task automatic test_single_mode();
    write_mode(ModeSingle);
    send_text("\n00\no\noooo\n\n\n99\n\n");
  endtask

  task automatic test_strength_mode();
    write_mode(ModeStrength);
    send_text("\n00\noooo\n12\r\n\n\n99\noo\noooooo0\nooo12\n");
  endtask

  task automatic test_mode_switch_in_reply();
    write_mode(2'd0);
    send_text("AB\n\n");
  endtask

  task automatic send_random_reply();
    int         shape;
    int         n;
    int         lines;
    logic [7:0] lead;
    logic [7:0] second;
    shape = $urandom_range(0, 19);
    n = $urandom_range(0, 4);
    repeat (n) send_byte(any_char());
    send_byte(LineFeed);
    if (shape == 0) begin
      n = $urandom_range(0, 1);
      repeat (n) send_byte(status_char());
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          lead   = CharNine;
          second = CharNine;
        end
        5, 6, 7: begin
          lead   = CharZero;
          second = CharZero;
        end
        default: begin
          lead   = status_char();
          second = status_char();
        end
      endcase
      send_byte(lead);
      send_byte(second);
      n = $urandom_range(0, 2);
      repeat (n) send_byte(any_char());
    end
    send_byte(LineFeed);
    if (shape != 1) begin
      n = (shape == 2) ? $urandom_range(1, 3) : $urandom_range(4, 6);
      repeat (n) send_byte(data_char());
      send_byte(LineFeed);
      lines = $urandom_range(1, 4);
      repeat (lines) begin
        n = $urandom_range(1, 14);
        repeat (n) send_byte(data_char());
        send_byte(LineFeed);
      end
    end
    send_byte(LineFeed);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 30);
    repeat (n) send_byte(($urandom_range(0, 5) == 0) ? LineFeed : 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_replies();
    int start;
    int reps;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      write_mode(2'($urandom_range(0, 3)));
      quiet = ($urandom_range(0, 4) == 0);
      reps  = $urandom_range(2, 8);
      repeat (reps) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_random_reply();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int run;
    bit level;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      level = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      run   = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
      out_stall_i <= level;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, got kind %0d main %0h strength %0h",
                 $time, item_kind_o, main_value_o, strength_value_o);
      end else begin
        want = predicted_beats.pop_front();
        kind_seen[item_kind_o]++;
        if (item_kind_o !== want.kind) begin
          errors++;
          $display("%0t: item_kind expected %0d, got %0d", $time, want.kind, item_kind_o);
        end
        if (main_value_o !== want.main_value) begin
          errors++;
          $display("%0t: main_value expected %0h, got %0h", $time, want.main_value,
                   main_value_o);
        end
        if (strength_value_o !== want.strength_value) begin
          errors++;
          $display("%0t: strength_value expected %0h, got %0h", $time, want.strength_value,
                   strength_value_o);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 2'd0;
    in_valid_i   = 1'b0;
    reply_byte_i = 8'h00;
    errors       = 0;
    bytes_sent   = 0;
    quiet        = 1'b0;
    cur_mode     = 2'd0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    clear_decoder();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_short_status();
    test_distance_reply();
    test_single_mode();
    test_strength_mode();
    test_mode_switch_in_reply();
    test_random_replies();
    wait_idle();
    $display("Sent %0d reply bytes in all four modes, directed cases first, then random.",
             bytes_sent);
    $display("Checked %0d timestamps, %0d measurements, %0d ok ends and %0d error ends.",
             kind_seen[KIND_TIMESTAMP], kind_seen[KIND_MEASURE], kind_seen[KIND_END_OK],
             kind_seen[KIND_END_ERROR]);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
